[sv/ffd_pkg.sv]
// ----------------------------------------------------------------------------
// ffd_pkg
// Shared constants, register and status codes, and the command/status
// bundles between the deframer controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ffd_pkg;

  // Default geometry
  localparam int FRAME_LEN_DEF  = 16;
  localparam int BUF_FRAMES_DEF = 3;

  // Fixed field widths
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 6;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  // Register reset values
  localparam logic [BYTE_W-1:0] HEADER_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] TRAILER_RST = 8'hBB;
  localparam logic [BYTE_W-1:0] CHECK_RST   = 8'hF0;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK   = 2'd2;

  // Frame status codes
  localparam logic [STATUS_W-1:0] ST_GOOD      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_CHECK = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_FRAME  = 2'd2;

  // Read port A address select
  typedef logic [1:0] rsel_t;
  localparam rsel_t RSEL_SCAN  = 2'd0;
  localparam rsel_t RSEL_CHK   = 2'd1;
  localparam rsel_t RSEL_EMIT  = 2'd2;
  localparam rsel_t RSEL_SHIFT = 2'd3;

  // Controller -> datapath
  typedef struct packed {
    logic  intake;       // take the offered request
    rsel_t rsel;         // read address select
    logic  scan_next;    // advance scan position
    logic  base_from_p;  // frame found at scan position
    logic  chk_load;     // latch frame status from check byte
    logic  emit_load;    // load one frame byte into output register
    logic  shift_init;   // start compaction after frame
    logic  shift_wr;     // move one byte down
    logic  shift_done;   // store count takes compacted length
    logic  count_clear;  // empty the store
    logic  nf_load;      // load the no-frame result
  } ffd_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic chunk_end;   // current request ends its chunk
    logic fast;        // chunk is one well-formed frame
    logic enough;      // store holds at least one frame length
    logic scan_hit;    // header and trailer match at scan position
    logic scan_more;   // another scan position remains
    logic emit_last;   // emitting final frame byte
    logic shift_more;  // bytes remain to compact
    logic out_free;    // output register can take a result
  } ffd_sts_t;

endpackage

`default_nettype wire

[sv/ffd_ctrl.sv]
// ----------------------------------------------------------------------------
// ffd_ctrl
// Sequencer for the deframer: intake, store scan, check byte read,
// frame emission and compaction of the store.
// ----------------------------------------------------------------------------
`default_nettype none

module ffd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire ffd_pkg::ffd_sts_t sts,
  output ffd_pkg::ffd_cmd_t     cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CMP = 4'd2;
  localparam logic [3:0] S_CHK_RD   = 4'd3;
  localparam logic [3:0] S_CHK_CMP  = 4'd4;
  localparam logic [3:0] S_EMIT_RD  = 4'd5;
  localparam logic [3:0] S_EMIT_WR  = 4'd6;
  localparam logic [3:0] S_SH_RD    = 4'd7;
  localparam logic [3:0] S_SH_WR    = 4'd8;
  localparam logic [3:0] S_NOFRAME  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       fast_r, fast_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    fast_nxt  = fast_r;
    cmd       = '0;
    cmd.rsel  = ffd_pkg::RSEL_SCAN;
    unique case (state_r)
      S_IDLE: begin
        cmd.intake = in_valid;
        if (in_valid && sts.chunk_end) begin
          fast_nxt = sts.fast;
          if (sts.fast) begin
            state_nxt = S_CHK_RD;
          end else if (sts.enough) begin
            state_nxt = S_SCAN_RD;
          end else begin
            state_nxt = S_NOFRAME;
          end
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts.scan_hit) begin
          cmd.base_from_p = 1'b1;
          state_nxt       = S_CHK_RD;
        end else if (sts.scan_more) begin
          cmd.scan_next = 1'b1;
          state_nxt     = S_SCAN_RD;
        end else begin
          state_nxt = S_NOFRAME;
        end
      end
      S_CHK_RD: begin
        cmd.rsel  = ffd_pkg::RSEL_CHK;
        state_nxt = S_CHK_CMP;
      end
      S_CHK_CMP: begin
        cmd.rsel     = ffd_pkg::RSEL_CHK;
        cmd.chk_load = 1'b1;
        state_nxt    = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        cmd.rsel  = ffd_pkg::RSEL_EMIT;
        state_nxt = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        cmd.rsel = ffd_pkg::RSEL_EMIT;
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (!sts.emit_last) begin
            state_nxt = S_EMIT_RD;
          end else if (fast_r) begin
            cmd.count_clear = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            cmd.shift_init = 1'b1;
            state_nxt      = S_SH_RD;
          end
        end
      end
      S_SH_RD: begin
        cmd.rsel = ffd_pkg::RSEL_SHIFT;
        if (sts.shift_more) begin
          state_nxt = S_SH_WR;
        end else begin
          cmd.shift_done = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_SH_WR: begin
        cmd.rsel     = ffd_pkg::RSEL_SHIFT;
        cmd.shift_wr = 1'b1;
        state_nxt    = S_SH_RD;
      end
      S_NOFRAME: begin
        if (sts.out_free) begin
          cmd.nf_load = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fast_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fast_r  <= fast_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/ffd_dp.sv]
// ----------------------------------------------------------------------------
// ffd_dp
// Deframer datapath: reassembly store, chunk counters, config registers,
// scan and compaction pointers, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffd_dp #(
  parameter int FRAME_LEN  = ffd_pkg::FRAME_LEN_DEF,
  parameter int BUF_FRAMES = ffd_pkg::BUF_FRAMES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ffd_pkg::ffd_cmd_t             cmd,
  output ffd_pkg::ffd_sts_t                  sts,
  input  wire logic [ffd_pkg::BYTE_W-1:0]    in_rx_byte,
  input  wire logic [ffd_pkg::LEN_W-1:0]     in_chunk_len,
  input  wire logic                          cfg_we,
  input  wire logic [ffd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ffd_pkg::BYTE_W-1:0]    cfg_wdata,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ffd_pkg::BYTE_W-1:0]         out_frame_byte,
  output logic [ffd_pkg::STATUS_W-1:0]       out_status,
  output logic                               out_last_of_run
);

  localparam int DEPTH = FRAME_LEN * BUF_FRAMES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int LW    = ffd_pkg::LEN_W;
  localparam int EW    = ((CW > LW) ? CW : LW) + 1;
  localparam int IW    = $clog2(FRAME_LEN);
  localparam int BW    = ffd_pkg::BYTE_W;

  localparam logic [CW-1:0] FL_C    = CW'(FRAME_LEN);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [IW-1:0] I_LAST  = IW'(FRAME_LEN - 1);

  // Config registers
  logic [BW-1:0] hdr_r, trl_r, chk_r;

  // Control state
  logic [CW-1:0] cnt_r;
  logic [LW-1:0] pos_r;
  logic [CW-1:0] start_r;
  logic          out_valid_r;

  // Payload state
  logic [BW-1:0]                first_r;
  logic [CW-1:0]                base_r, p_r, j_r, k_r;
  logic [IW-1:0]                i_r;
  logic [ffd_pkg::STATUS_W-1:0] status_r;
  logic [BW-1:0]                out_byte_r;
  logic [ffd_pkg::STATUS_W-1:0] out_status_r;
  logic                         out_last_r;

  // Store
  logic [BW-1:0] mem [DEPTH];
  logic [BW-1:0] rd_a_r, rd_b_r;
  logic [CW-1:0] raddr_a, raddr_b, waddr;
  logic [BW-1:0] wdata;
  logic          mem_we;

  // Intake terms
  logic [LW-1:0] len_eff, taken;
  logic          wrap, room;
  logic [CW-1:0] cnt_eff, cnt_new, start_eff;
  logic [BW-1:0] first_sel;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= ffd_pkg::HEADER_RST;
      trl_r <= ffd_pkg::TRAILER_RST;
      chk_r <= ffd_pkg::CHECK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ffd_pkg::REG_HEADER:  hdr_r <= cfg_wdata;
        ffd_pkg::REG_TRAILER: trl_r <= cfg_wdata;
        ffd_pkg::REG_CHECK:   chk_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Chunk bookkeeping for the offered byte
  always_comb begin
    len_eff   = (in_chunk_len == '0) ? LW'(1) : in_chunk_len;
    wrap      = (pos_r == '0) && ((EW'(cnt_r) + EW'(len_eff)) > EW'(DEPTH));
    cnt_eff   = wrap ? '0 : cnt_r;
    start_eff = (pos_r == '0) ? cnt_eff : start_r;
    room      = (cnt_eff < DEPTH_C);
    cnt_new   = room ? (cnt_eff + CW'(1)) : cnt_eff;
    taken     = pos_r + LW'(1);
    first_sel = (pos_r == '0) ? in_rx_byte : first_r;
  end

  // Status to controller
  always_comb begin
    sts.chunk_end  = (taken >= len_eff);
    sts.fast       = (EW'(taken) == EW'(FRAME_LEN)) && ((cnt_new - start_eff) == FL_C) &&
                     (first_sel == hdr_r) && (in_rx_byte == trl_r);
    sts.enough     = (cnt_new >= FL_C);
    sts.scan_hit   = (rd_a_r == hdr_r) && (rd_b_r == trl_r);
    sts.scan_more  = ((CW+1)'(p_r) + (CW+1)'(FRAME_LEN + 1)) <= (CW+1)'(cnt_r);
    sts.emit_last  = (i_r == I_LAST);
    sts.shift_more = (j_r < cnt_r);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  // Read address select
  always_comb begin
    case (cmd.rsel)
      ffd_pkg::RSEL_SCAN:  raddr_a = p_r;
      ffd_pkg::RSEL_CHK:   raddr_a = base_r + CW'(FRAME_LEN - 2);
      ffd_pkg::RSEL_EMIT:  raddr_a = base_r + CW'(i_r);
      ffd_pkg::RSEL_SHIFT: raddr_a = j_r;
      default:             raddr_a = p_r;
    endcase
    raddr_b = p_r + CW'(FRAME_LEN - 1);
  end

  // Write port: intake byte or compaction move
  always_comb begin
    mem_we = 1'b0;
    waddr  = cnt_eff;
    wdata  = in_rx_byte;
    if (cmd.intake) begin
      mem_we = room;
    end else if (cmd.shift_wr) begin
      mem_we = 1'b1;
      waddr  = k_r;
      wdata  = rd_a_r;
    end
  end

  // Store: one write, two registered reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    rd_a_r <= mem[raddr_a[AW-1:0]];
    rd_b_r <= mem[raddr_b[AW-1:0]];
  end

  // Counters and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pos_r       <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.intake) begin
        cnt_r   <= cnt_new;
        start_r <= start_eff;
        pos_r   <= sts.chunk_end ? '0 : taken;
      end else if (cmd.count_clear) begin
        cnt_r <= '0;
      end else if (cmd.shift_done) begin
        cnt_r <= k_r;
      end
      if (cmd.emit_load || cmd.nf_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Pointers and output payload
  always_ff @(posedge clk) begin
    if (cmd.intake) begin
      base_r <= start_eff;
      p_r    <= '0;
      if (pos_r == '0) begin
        first_r <= in_rx_byte;
      end
    end
    if (cmd.scan_next) begin
      p_r <= p_r + CW'(1);
    end
    if (cmd.base_from_p) begin
      base_r <= p_r;
    end
    if (cmd.chk_load) begin
      status_r <= (rd_a_r == chk_r) ? ffd_pkg::ST_GOOD : ffd_pkg::ST_BAD_CHECK;
      i_r      <= '0;
    end
    if (cmd.emit_load) begin
      out_byte_r   <= rd_a_r;
      out_status_r <= status_r;
      out_last_r   <= (i_r == I_LAST);
      i_r          <= i_r + IW'(1);
    end
    if (cmd.nf_load) begin
      out_byte_r   <= '0;
      out_status_r <= ffd_pkg::ST_NO_FRAME;
      out_last_r   <= 1'b1;
    end
    if (cmd.shift_init) begin
      j_r <= base_r + FL_C;
      k_r <= '0;
    end
    if (cmd.shift_wr) begin
      j_r <= j_r + CW'(1);
      k_r <= k_r + CW'(1);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_byte  = out_byte_r;
  assign out_status      = out_status_r;
  assign out_last_of_run = out_last_r;

endmodule

`default_nettype wire

[sv/fixed_frame_deframer.sv]
// ----------------------------------------------------------------------------
// fixed_frame_deframer
// Reassembles received chunks and extracts fixed-length frames delimited by
// a header and a trailer byte.
// ----------------------------------------------------------------------------
// A byte that does not end its chunk is taken with no stall. A chunk-ending
// byte holds the input stalled while the store is worked on through its
// single write port and two registered read ports: each scan position is
// read and compared, as is the check byte, then each of the FRAME_LEN frame
// bytes is read and loaded into the output register, waiting if the output
// stalls; then each kept byte is read and moved to the front. A one-frame
// chunk skips scan and move. No frame found gives one status result. The
// store needs no clearing after reset: only bytes written since are ever read.
`default_nettype none

module fixed_frame_deframer #(
  parameter int FRAME_LEN  = ffd_pkg::FRAME_LEN_DEF,
  parameter int BUF_FRAMES = ffd_pkg::BUF_FRAMES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ffd_pkg::BYTE_W-1:0]    in_rx_byte,
  input  wire logic [ffd_pkg::LEN_W-1:0]     in_chunk_len,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ffd_pkg::BYTE_W-1:0]         out_frame_byte,
  output logic [ffd_pkg::STATUS_W-1:0]       out_status,
  output logic                               out_last_of_run,
  input  wire logic                          cfg_we,
  input  wire logic [ffd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ffd_pkg::BYTE_W-1:0]    cfg_wdata
);

  ffd_pkg::ffd_cmd_t cmd;
  ffd_pkg::ffd_sts_t sts;

  // Sequencer
  ffd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Store and datapath
  ffd_dp #(
    .FRAME_LEN  (FRAME_LEN),
    .BUF_FRAMES (BUF_FRAMES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_rx_byte      (in_rx_byte),
    .in_chunk_len    (in_chunk_len),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_byte  (out_frame_byte),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run)
  );

  // A chunk-ending request always starts chunk-end processing
  a_chunk_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && sts.chunk_end |=> in_stall)
    else $error("chunk end did not start processing");

  // A no-frame result is a single zero byte closing the run
  a_noframe_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ffd_pkg::ST_NO_FRAME) |-> out_last_of_run &&
    (out_frame_byte == '0))
    else $error("malformed no-frame result");

  // No result is loaded while new bytes are being taken
  a_no_emit_in_intake: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !cmd.emit_load && !cmd.nf_load && !cmd.shift_wr)
    else $error("result or compaction during intake");

endmodule

`default_nettype wire

[dv/fixed_frame_deframer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_frame_deframer_tb
// Self-checking bench for the fixed-length frame deframer. Received bytes are
// sent in chunks through a table of directed cases, then through random
// chunk streams under several header, trailer and check settings. Every
// result request is compared with a frame predictor kept in this bench, under
// random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------

module fixed_frame_deframer_tb;

  localparam int FRAME_LEN     = ffd_pkg::FRAME_LEN_DEF;
  localparam int STORE_DEPTH   = ffd_pkg::FRAME_LEN_DEF * ffd_pkg::BUF_FRAMES_DEF;
  localparam int SETTLE_CYCLES = 150;   // compaction after the last result byte
  localparam int IDLE_LIMIT    = 2000;
  localparam int N_PHASES      = 5;
  localparam int PHASE_ITEMS   = 30;
  localparam int PRINT_CAP     = 50;
  // no register behind this index
  localparam logic [ffd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [ffd_pkg::BYTE_W-1:0]   fbyte;
    logic [ffd_pkg::STATUS_W-1:0] status;
    logic                         run_end;
  } frame_res_t;

  typedef enum {ROW_FRAME, ROW_BAD_CHECK, ROW_FILL, ROW_MIXED} row_kind_t;

  typedef struct {
    row_kind_t                    kind;
    int                           first;      // frame byte index of the row's first byte
    int                           nbytes;
    logic [ffd_pkg::LEN_W-1:0]    len_tag;    // length carried by all but the last byte
    logic [ffd_pkg::LEN_W-1:0]    len_end;    // length carried by the last byte
    logic [ffd_pkg::BYTE_W-1:0]   fill;
    bit                           fixed_status;
    logic [ffd_pkg::STATUS_W-1:0] status_val;
  } dir_row_t;

  localparam int DIR_ROWS = 13;

  // Directed chunks, all under the reset register values
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_FRAME,     0, 16, 6'd16, 6'd16, 8'h00, 1'b1, ffd_pkg::ST_GOOD},      // whole frame
    '{ROW_BAD_CHECK, 0, 16, 6'd16, 6'd16, 8'h00, 1'b1, ffd_pkg::ST_BAD_CHECK}, // wrong check
    '{ROW_FILL,      0,  1, 6'd0,  6'd0,  8'h00, 1'b1, ffd_pkg::ST_NO_FRAME},  // zero length
    '{ROW_FILL,      0, 63, 6'd63, 6'd63, 8'hFF, 1'b1, ffd_pkg::ST_NO_FRAME},  // overflow
    '{ROW_FRAME,     0,  8, 6'd8,  6'd8,  8'h00, 1'b1, ffd_pkg::ST_NO_FRAME},  // frame front
    '{ROW_FRAME,     8,  8, 6'd8,  6'd8,  8'h00, 1'b1, ffd_pkg::ST_GOOD},      // frame back
    '{ROW_MIXED,     0, 24, 6'd24, 6'd24, 8'h00, 1'b0, ffd_pkg::ST_GOOD},      // frame in noise
    '{ROW_FRAME,     0, 16, 6'd16, 6'd16, 8'h00, 1'b1, ffd_pkg::ST_GOOD},      // over leftovers
    '{ROW_FILL,      0, 40, 6'd40, 6'd40, 8'h55, 1'b1, ffd_pkg::ST_NO_FRAME},  // nearly full
    '{ROW_FRAME,     0,  1, 6'd8,  6'd8,  8'h00, 1'b0, ffd_pkg::ST_GOOD},      // fits at start
    '{ROW_FRAME,     1, 15, 6'd16, 6'd16, 8'h00, 1'b1, ffd_pkg::ST_NO_FRAME},  // then drops
    '{ROW_FILL,      0,  4, 6'd12, 6'd12, 8'h5A, 1'b0, ffd_pkg::ST_GOOD},      // open chunk
    '{ROW_FILL,      0,  3, 6'd20, 6'd2,  8'h5A, 1'b1, ffd_pkg::ST_NO_FRAME}   // length shrinks
  };

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [ffd_pkg::BYTE_W-1:0]    in_rx_byte;
  logic [ffd_pkg::LEN_W-1:0]     in_chunk_len;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [ffd_pkg::BYTE_W-1:0]    out_frame_byte;
  logic [ffd_pkg::STATUS_W-1:0]  out_status;
  logic                          out_last_of_run;
  logic                          cfg_we;
  logic [ffd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ffd_pkg::BYTE_W-1:0]    cfg_wdata;

  // Predictor state
  logic [ffd_pkg::BYTE_W-1:0] frag_store [STORE_DEPTH];
  int                         fill_level;
  int                         chunk_taken;
  int                         chunk_base;
  logic [ffd_pkg::BYTE_W-1:0] hdr_cfg, trl_cfg, chk_cfg;
  frame_res_t                 frame_burst [FRAME_LEN];
  int                         burst_len;

  frame_res_t                 due_bytes_q [$];
  logic [ffd_pkg::BYTE_W-1:0] seg_q [$];

  int mismatches   = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int good_frames  = 0;
  int bad_frames   = 0;
  int empty_scans  = 0;
  int burst_left   = 0;
  int idle_cycles  = 0;
  int stall_cyc    = 0;
  int stall_mode   = 0;

  fixed_frame_deframer uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .in_chunk_len   (in_chunk_len),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_status     (out_status),
    .out_last_of_run(out_last_of_run),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  // Takes one byte into the frame predictor; fills frame_burst on a chunk end
  task automatic reassemble_byte(input logic [ffd_pkg::BYTE_W-1:0] b,
                                 input logic [ffd_pkg::LEN_W-1:0] len_f);
    int                           len, taken, base, p, k;
    bit                           fast;
    logic [ffd_pkg::STATUS_W-1:0] st;
    len = (len_f == 0) ? 1 : int'(len_f);
    burst_len = 0;
    if (chunk_taken == 0) begin
      if (fill_level + len > STORE_DEPTH) fill_level = 0;
      chunk_base = fill_level;
    end
    // bytes past a full store are counted but lost
    if (fill_level < STORE_DEPTH) begin
      frag_store[fill_level] = b;
      fill_level++;
    end
    taken = chunk_taken + 1;
    if (taken < len) begin
      chunk_taken = taken;
      return;
    end
    chunk_taken = 0;
    base = -1;
    fast = 1'b0;
    // chunk is exactly one well-delimited frame
    if (taken == FRAME_LEN && fill_level - chunk_base == FRAME_LEN &&
        frag_store[chunk_base] == hdr_cfg &&
        frag_store[chunk_base + FRAME_LEN - 1] == trl_cfg) begin
      base = chunk_base;
      fast = 1'b1;
    end else begin
      for (p = 0; p + FRAME_LEN <= fill_level && base < 0; p++) begin
        if (frag_store[p] == hdr_cfg && frag_store[p + FRAME_LEN - 1] == trl_cfg) base = p;
      end
    end
    if (base < 0) begin
      frame_burst[0] = '{fbyte: '0, status: ffd_pkg::ST_NO_FRAME, run_end: 1'b1};
      burst_len = 1;
      return;
    end
    st = (frag_store[base + FRAME_LEN - 2] == chk_cfg) ? ffd_pkg::ST_GOOD
                                                        : ffd_pkg::ST_BAD_CHECK;
    for (k = 0; k < FRAME_LEN; k++) begin
      frame_burst[k] = '{fbyte: frag_store[base + k], status: st,
                         run_end: (k == FRAME_LEN - 1)};
    end
    burst_len = FRAME_LEN;
    if (fast) begin
      fill_level = 0;
    end else begin
      // keep only what follows the frame
      for (k = 0; base + FRAME_LEN + k < fill_level; k++) begin
        frag_store[k] = frag_store[base + FRAME_LEN + k];
      end
      fill_level = k;
    end
  endtask

  // One input request; called and returns at a falling edge
  task automatic send_request(input logic [ffd_pkg::BYTE_W-1:0] b,
                              input logic [ffd_pkg::LEN_W-1:0] len_f,
                              input bit fixed_status,
                              input logic [ffd_pkg::STATUS_W-1:0] status_val);
    int         gap, k;
    frame_res_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_rx_byte   <= b;
    in_chunk_len <= len_f;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    items_sent++;
    burst_left--;
    reassemble_byte(b, len_f);
    for (k = 0; k < burst_len; k++) begin
      r = frame_burst[k];
      if (fixed_status) r.status = status_val;
      due_bytes_q.push_back(r);
    end
    @(negedge clk);
  endtask

  // Sender holds off until every result is out and the block is quiet
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (due_bytes_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ffd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ffd_pkg::BYTE_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      ffd_pkg::REG_HEADER:  hdr_cfg = data;
      ffd_pkg::REG_TRAILER: trl_cfg = data;
      ffd_pkg::REG_CHECK:   chk_cfg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [ffd_pkg::BYTE_W-1:0] frame_byte_at(input int f,
                                                               input bit good_check);
    if (f == 0) return hdr_cfg;
    if (f == FRAME_LEN - 1) return trl_cfg;
    if (f == FRAME_LEN - 2) return good_check ? chk_cfg : chk_cfg ^ 8'($urandom_range(1, 255));
    return 8'($urandom);
  endfunction

  function automatic logic [ffd_pkg::BYTE_W-1:0] row_byte(input dir_row_t r, input int i);
    int f;
    f = (r.kind == ROW_MIXED) ? i - 3 : r.first + i;
    if (r.kind == ROW_FILL) return r.fill;
    if (f < 0 || f >= FRAME_LEN) return 8'($urandom);
    return frame_byte_at(f, r.kind != ROW_BAD_CHECK);
  endfunction

  // Random chunk content: frames with stray delimiters in them, and noise
  task automatic push_frame(input bit good_check);
    int f;
    for (f = 0; f < FRAME_LEN; f++) seg_q.push_back(frame_byte_at(f, good_check));
    for (f = 1; f < FRAME_LEN - 2; f++) begin
      if ($urandom_range(0, 9) == 0) seg_q[seg_q.size() - FRAME_LEN + f] = hdr_cfg;
      else if ($urandom_range(0, 9) == 0) seg_q[seg_q.size() - FRAME_LEN + f] = trl_cfg;
    end
  endtask

  task automatic push_noise(input int n);
    int k, pick;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 9);
      seg_q.push_back(pick == 0 ? hdr_cfg : pick == 1 ? trl_cfg : 8'($urandom));
    end
  endtask

  task automatic send_chunk();
    logic [ffd_pkg::LEN_W-1:0] len_f;
    len_f = ffd_pkg::LEN_W'(seg_q.size());
    while (seg_q.size() != 0) send_request(seg_q.pop_front(), len_f, 1'b0, ffd_pkg::ST_GOOD);
  endtask

  task automatic send_pieces(input int max_piece);
    int n, k;
    while (seg_q.size() != 0) begin
      n = $urandom_range(1, (seg_q.size() < max_piece) ? seg_q.size() : max_piece);
      for (k = 0; k < n; k++) begin
        send_request(seg_q.pop_front(), ffd_pkg::LEN_W'(n), 1'b0, ffd_pkg::ST_GOOD);
      end
    end
  endtask

  task automatic run_random(input int n);
    int                        stop, shape, target;
    logic [ffd_pkg::LEN_W-1:0] tag;
    stop = items_sent + n;
    while (items_sent < stop) begin
      shape = $urandom_range(0, 99);
      seg_q.delete();
      if (shape < 35) begin
        // one frame per chunk, now and then with a broken trailer
        push_frame($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 7) == 0) seg_q[FRAME_LEN - 1] = ~trl_cfg;
        send_chunk();
      end else if (shape < 60) begin
        // frames inside noise, cut into chunks at random
        push_noise($urandom_range(0, 5));
        push_frame(1'b1);
        push_noise($urandom_range(0, 5));
        if ($urandom_range(0, 1) == 1) push_frame($urandom_range(0, 1) == 1);
        send_pieces(24);
      end else if (shape < 70) begin
        push_noise($urandom_range(1, STORE_DEPTH));
        send_chunk();
      end else if (shape < 80) begin
        // chunks near or past the store size
        target = $urandom_range(36, 63);
        while (seg_q.size() < target) begin
          if ($urandom_range(0, 1) == 1) push_frame(1'b1);
          else push_noise($urandom_range(1, 6));
        end
        while (seg_q.size() > 63) void'(seg_q.pop_back());
        send_chunk();
      end else begin
        // length changing from byte to byte
        push_noise($urandom_range(0, 3));
        push_frame(1'b1);
        push_noise($urandom_range(0, 3));
        while (seg_q.size() != 0) begin
          case ($urandom_range(0, 11))
            0, 1:    tag = '0;
            2:       tag = '1;
            default: tag = ffd_pkg::LEN_W'($urandom_range(1, 20));
          endcase
          send_request(seg_q.pop_front(), tag, 1'b0, ffd_pkg::ST_GOOD);
        end
        if (chunk_taken != 0) send_request(8'($urandom), 6'd1, 1'b0, ffd_pkg::ST_GOOD);
      end
    end
  endtask

  // Receiver stall pattern, in one of four modes picked at random
  always @(negedge clk) begin
    if (stall_cyc % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 9) < 3);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ((stall_cyc % 5) < 2);
    endcase
    stall_cyc++;
  end

  // Result checker
  always @(posedge clk) begin
    frame_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (due_bytes_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h status %0d last %0b",
                                  out_frame_byte, out_status, out_last_of_run));
      end else begin
        want = due_bytes_q.pop_front();
        if (out_frame_byte !== want.fbyte)
          report_mismatch($sformatf("result %0d frame_byte %02h, want %02h",
                                    results_seen, out_frame_byte, want.fbyte));
        if (out_status !== want.status)
          report_mismatch($sformatf("result %0d status %0d, want %0d",
                                    results_seen, out_status, want.status));
        if (out_last_of_run !== want.run_end)
          report_mismatch($sformatf("result %0d last_of_run %0b, want %0b",
                                    results_seen, out_last_of_run, want.run_end));
        if (want.run_end) begin
          case (want.status)
            ffd_pkg::ST_GOOD:      good_frames++;
            ffd_pkg::ST_BAD_CHECK: bad_frames++;
            default:               empty_scans++;
          endcase
        end
      end
    end
  end

  // Watchdog on cycles with no request moving on either side
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[%0t] no request moved for %0d cycles", $time, IDLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus
  initial begin
    int                         r, i, ph;
    logic [ffd_pkg::BYTE_W-1:0] v;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_rx_byte   = '0;
    in_chunk_len = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    fill_level   = 0;
    chunk_taken  = 0;
    chunk_base   = 0;
    hdr_cfg      = ffd_pkg::HEADER_RST;
    trl_cfg      = ffd_pkg::TRAILER_RST;
    chk_cfg      = ffd_pkg::CHECK_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (r = 0; r < DIR_ROWS; r++) begin
      for (i = 0; i < dir_rows[r].nbytes; i++) begin
        send_request(row_byte(dir_rows[r], i),
                     (i == dir_rows[r].nbytes - 1) ? dir_rows[r].len_end : dir_rows[r].len_tag,
                     dir_rows[r].fixed_status && (i == dir_rows[r].nbytes - 1),
                     dir_rows[r].status_val);
      end
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      drain_and_settle();
      case (ph)
        0: begin
          write_reg(ffd_pkg::REG_HEADER, 8'h00);
          write_reg(ffd_pkg::REG_TRAILER, 8'hFF);
          write_reg(ffd_pkg::REG_CHECK, 8'h00);
        end
        1: begin
          write_reg(ffd_pkg::REG_HEADER, 8'hFF);
          write_reg(ffd_pkg::REG_TRAILER, 8'h00);
          write_reg(ffd_pkg::REG_CHECK, 8'hFF);
        end
        2: begin
          write_reg(ffd_pkg::REG_HEADER, 8'($urandom));
          write_reg(ffd_pkg::REG_TRAILER, 8'($urandom));
          write_reg(ffd_pkg::REG_CHECK, 8'($urandom));
        end
        3: begin
          // same value opens and closes a frame
          v = 8'($urandom);
          write_reg(ffd_pkg::REG_HEADER, v);
          write_reg(ffd_pkg::REG_TRAILER, v);
          write_reg(ffd_pkg::REG_CHECK, 8'($urandom));
        end
        default: begin
          write_reg(ffd_pkg::REG_HEADER, ffd_pkg::HEADER_RST);
          write_reg(ffd_pkg::REG_TRAILER, ffd_pkg::TRAILER_RST);
          write_reg(ffd_pkg::REG_CHECK, ffd_pkg::CHECK_RST);
        end
      endcase
      write_reg(REG_SPARE, 8'($urandom));
      run_random(PHASE_ITEMS);
    end
    drain_and_settle();

    $display("Sent %0d bytes under %0d register settings; checked %0d result bytes.",
             items_sent, N_PHASES + 1, results_seen);
    $display("Chunk ends: %0d good frames, %0d check mismatches, %0d without a frame.",
             good_frames, bad_frames, empty_scans);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
sv/ffd_pkg.sv
sv/ffd_ctrl.sv
sv/ffd_dp.sv
sv/fixed_frame_deframer.sv
dv/fixed_frame_deframer_tb.sv
